// File: rtl/wcg_pkg.sv
// ----------------------------------------------------------------------------
// wcg_pkg - window coefficient generator shared definitions
// Types, constants and arithmetic helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package wcg_pkg;

  // Field and port widths
  localparam int MAX_LENGTH = 4096;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int TYPE_W     = 3;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd256;
  localparam logic [LEN_W-1:0] LEN_MIN   = 13'd2;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);

  localparam logic [COEF_W-1:0] Q15_ONE = 16'd32768;

  typedef enum logic [TYPE_W-1:0] {
    WIN_RECT     = 3'd0,
    WIN_TRI      = 3'd1,
    WIN_HANN     = 3'd2,
    WIN_HAMMING  = 3'd3,
    WIN_BLACKMAN = 3'd4,
    WIN_PARZEN   = 3'd5,
    WIN_WELCH    = 3'd6
  } win_type_t;

  // Q30 arithmetic
  localparam int P_W = 34;
  localparam int Z_W = 31;
  typedef logic signed [P_W-1:0] q30_t;

  localparam q30_t Q30_ONE = 34'sd1073741824;
  localparam q30_t K_H54   = 34'sd579820585;
  localparam q30_t K_B42   = 34'sd450971566;
  localparam logic [Z_W-1:0] K_H46  = 31'd493921239;
  localparam logic [Z_W-1:0] K_B08  = 31'd85899346;
  localparam logic [Z_W-1:0] K_HALF = 31'd536870912;

  localparam int POLY_N = 7;
  localparam q30_t COS_POLY [POLY_N] = '{
    34'sd1073741824, 34'sd1324675879, 34'sd272375560, 34'sd22401993,
    34'sd987048, 34'sd27061, 34'sd506
  };

  // Divider geometry: phase lane and ratio lane advance in lockstep
  localparam int PH_D_W     = 13;
  localparam int PH_Q_W     = 36;
  localparam int PH_STEPS   = 4;
  localparam int DIV_STAGES = PH_Q_W / PH_STEPS;
  localparam int RT_D_W     = 26;
  localparam int RT_STEPS   = 2;
  localparam int RT_Q_W     = RT_STEPS * DIV_STAGES;
  localparam int NUM_W      = 25;
  localparam int RT_N_W     = NUM_W + 17;

  // Pipeline depths
  localparam int HORNER_STAGES = POLY_N - 1;
  localparam int COS_STAGES    = HORNER_STAGES + 3;
  localparam int PREP_STAGES   = 2;
  localparam int MIX_STAGES    = 2;
  localparam int LATENCY = PREP_STAGES + DIV_STAGES + COS_STAGES + MIX_STAGES;

  typedef struct packed {
    logic [IDX_W-1:0]  j;
    logic [IDX_W-1:0]  nm1;
    logic [LEN_W-1:0]  n1;
    logic [IDX_W-1:0]  d;
    logic [IDX_W-1:0]  m;
    logic [TYPE_W-1:0] wtype;
    logic              oor;
  } prep_t;

  typedef struct packed {
    logic [PH_D_W-1:0] ph_rem;
    logic [PH_Q_W-1:0] ph_w;
    logic [PH_D_W-1:0] ph_d;
    logic [RT_D_W-1:0] rt_rem;
    logic [RT_Q_W-1:0] rt_w;
    logic [RT_D_W-1:0] rt_d;
    logic [TYPE_W-1:0] wtype;
    logic              oor;
  } div_t;

  typedef struct packed {
    logic [TYPE_W-1:0] wtype;
    logic              oor;
    logic [RT_Q_W-1:0] ratio_q;
  } sb_t;

  // Signed Q30 times unsigned Q30, truncated toward zero
  function automatic q30_t mulq(input q30_t a, input logic [Z_W-1:0] b);
    logic [P_W-1:0]     mag;
    logic [P_W+Z_W-1:0] prod;
    logic [P_W-1:0]     res;
    mag  = a[P_W-1] ? P_W'(-a) : P_W'(a);
    prod = (P_W+Z_W)'(mag) * (P_W+Z_W)'(b);
    res  = prod[P_W+29:30];
    return a[P_W-1] ? -q30_t'(res) : q30_t'(res);
  endfunction

  // One divider stage: restoring steps on both lanes
  function automatic div_t div_stage(input div_t s);
    div_t              r;
    logic [PH_D_W:0]   pt;
    logic [RT_D_W:0]   rtt;
    r = s;
    for (int k = 0; k < PH_STEPS; k++) begin
      pt = {r.ph_rem, r.ph_w[PH_Q_W-1]};
      if (pt >= {1'b0, r.ph_d}) begin
        r.ph_rem = PH_D_W'(pt - {1'b0, r.ph_d});
        r.ph_w   = {r.ph_w[PH_Q_W-2:0], 1'b1};
      end else begin
        r.ph_rem = pt[PH_D_W-1:0];
        r.ph_w   = {r.ph_w[PH_Q_W-2:0], 1'b0};
      end
    end
    for (int k = 0; k < RT_STEPS; k++) begin
      rtt = {r.rt_rem, r.rt_w[RT_Q_W-1]};
      if (rtt >= {1'b0, r.rt_d}) begin
        r.rt_rem = RT_D_W'(rtt - {1'b0, r.rt_d});
        r.rt_w   = {r.rt_w[RT_Q_W-2:0], 1'b1};
      end else begin
        r.rt_rem = rtt[RT_D_W-1:0];
        r.rt_w   = {r.rt_w[RT_Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/window_coefficient_generator.sv
// ----------------------------------------------------------------------------
// window_coefficient_generator - window coefficient generator top level
// Returns the Q1.15 window coefficient for a sample index.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+-----------------------
//  input   | start, busy, in_sample_index            | start && !busy
//  result  | out_valid, out_coefficient,             | out_valid (one cycle)
//          | out_index_out_of_range                  |
//  config  | cfg_we, cfg_index, cfg_data             | cfg_we
//
// One item per cycle; each result passes through the prep stages, the 9-stage
// divider, the cosine units with their Horner chain and the mix stages.
// busy is always low: the pipeline never backs up.
// Reset clears the valid bits and the registers (type rectangular, N 256).
// ----------------------------------------------------------------------------
module window_coefficient_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [wcg_pkg::IDX_W-1:0]         in_sample_index,
  output logic                              out_valid,
  output logic [wcg_pkg::COEF_W-1:0]        out_coefficient,
  output logic                              out_index_out_of_range,
  input  logic                              cfg_we,
  input  logic [wcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CS = wcg_pkg::COS_STAGES;

  logic [wcg_pkg::TYPE_W-1:0]  window_type_r;
  logic [wcg_pkg::LEN_W-1:0]   window_length_r;

  logic                        prep_valid;
  wcg_pkg::div_t               prep_div;
  logic                        div_valid;
  logic [31:0]                 ph;
  wcg_pkg::sb_t                div_sb;
  logic                        cos_valid;
  wcg_pkg::q30_t               c1, c2;
  wcg_pkg::sb_t                sb_r [CS];

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_type_r   <= wcg_pkg::TYPE_W'(wcg_pkg::WIN_RECT);
      window_length_r <= wcg_pkg::LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcg_pkg::CFG_WINDOW_TYPE:   window_type_r   <= cfg_data[wcg_pkg::TYPE_W-1:0];
        wcg_pkg::CFG_WINDOW_LENGTH: window_length_r <= cfg_data[wcg_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  wcg_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (start & ~busy),
    .sample_index_i  (in_sample_index),
    .window_type_i   (window_type_r),
    .window_length_i (window_length_r),
    .valid_o         (prep_valid),
    .div_o           (prep_div)
  );

  wcg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (prep_valid),
    .div_i   (prep_div),
    .valid_o (div_valid),
    .ph_o    (ph),
    .sb_o    (div_sb)
  );

  // First and second harmonic
  wcg_cos u_cos1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (div_valid),
    .ph_i    (ph),
    .valid_o (cos_valid),
    .cos_o   (c1)
  );

  wcg_cos u_cos2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (div_valid),
    .ph_i    ({ph[30:0], 1'b0}),
    .valid_o (),
    .cos_o   (c2)
  );

  // Sideband delay alongside the cosine units
  for (genvar s = 0; s < CS; s++) begin : g_sb
    if (s == 0) begin : g_first
      always_ff @(posedge clk) sb_r[s] <= div_sb;
    end else begin : g_rest
      always_ff @(posedge clk) sb_r[s] <= sb_r[s-1];
    end
  end

  wcg_mix u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (cos_valid),
    .c1_i          (c1),
    .c2_i          (c2),
    .sb_i          (sb_r[CS-1]),
    .valid_o       (out_valid),
    .coefficient_o (out_coefficient),
    .oor_o         (out_index_out_of_range)
  );

endmodule

// File: rtl/wcg_prep.sv
// ----------------------------------------------------------------------------
// wcg_prep - index preparation
// Clamps N, flags out-of-range indexes and forms the divider operands.
// ----------------------------------------------------------------------------
module wcg_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [wcg_pkg::IDX_W-1:0]     sample_index_i,
  input  logic [wcg_pkg::TYPE_W-1:0]    window_type_i,
  input  logic [wcg_pkg::LEN_W-1:0]     window_length_i,
  output logic                          valid_o,
  output wcg_pkg::div_t                 div_o
);

  localparam int PH_N_W = wcg_pkg::IDX_W + 33;

  logic                        a_valid_r;
  wcg_pkg::prep_t              a_r, a_nxt;
  logic                        b_valid_r;
  wcg_pkg::div_t               b_r, b_nxt;

  logic [wcg_pkg::LEN_W-1:0]   n;
  logic [wcg_pkg::LEN_W-1:0]   two_j;
  logic [wcg_pkg::IDX_W-1:0]   rj;

  logic [PH_N_W-1:0]           ph_num;
  logic [wcg_pkg::RT_D_W-1:0]  sq_n1, sq_d;
  logic [wcg_pkg::NUM_W-1:0]   num, den;
  logic [wcg_pkg::RT_N_W-1:0]  rt_num;

  // Stage A: length clamp, range flag, distance terms
  always_comb begin
    if (window_length_i < wcg_pkg::LEN_MIN)      n = wcg_pkg::LEN_MIN;
    else if (window_length_i > wcg_pkg::LEN_MAX) n = wcg_pkg::LEN_MAX;
    else                                         n = window_length_i;
    a_nxt.j     = sample_index_i;
    a_nxt.nm1   = wcg_pkg::IDX_W'(n - 13'd1);
    a_nxt.n1    = n + 13'd1;
    a_nxt.wtype = window_type_i;
    a_nxt.oor   = sample_index_i > a_nxt.nm1;
    two_j       = {sample_index_i, 1'b0};
    if (two_j >= {1'b0, a_nxt.nm1}) a_nxt.d = wcg_pkg::IDX_W'(two_j - {1'b0, a_nxt.nm1});
    else                            a_nxt.d = wcg_pkg::IDX_W'({1'b0, a_nxt.nm1} - two_j);
    rj      = a_nxt.nm1 - sample_index_i;
    a_nxt.m = (sample_index_i < rj) ? sample_index_i : rj;
  end

  // Stage B: dividend, divisor and first remainder of both lanes
  always_comb begin
    ph_num = {a_r.j, 33'd0} | PH_N_W'(a_r.nm1);
    sq_n1  = wcg_pkg::RT_D_W'(a_r.n1) * wcg_pkg::RT_D_W'(a_r.n1);
    sq_d   = wcg_pkg::RT_D_W'(a_r.d) * wcg_pkg::RT_D_W'(a_r.d);
    case (wcg_pkg::win_type_t'(a_r.wtype))
      wcg_pkg::WIN_TRI: begin
        num = wcg_pkg::NUM_W'({a_r.m, 1'b0});
        den = wcg_pkg::NUM_W'(a_r.nm1);
      end
      wcg_pkg::WIN_PARZEN: begin
        num = wcg_pkg::NUM_W'(a_r.n1 - wcg_pkg::LEN_W'(a_r.d));
        den = wcg_pkg::NUM_W'(a_r.n1);
      end
      wcg_pkg::WIN_WELCH: begin
        num = wcg_pkg::NUM_W'(sq_n1 - sq_d);
        den = wcg_pkg::NUM_W'(sq_n1);
      end
      default: begin
        num = '0;
        den = wcg_pkg::NUM_W'(1);
      end
    endcase
    rt_num = (wcg_pkg::RT_N_W'(num) << 16) + wcg_pkg::RT_N_W'(den);

    b_nxt.ph_rem = wcg_pkg::PH_D_W'(ph_num >> wcg_pkg::PH_Q_W);
    b_nxt.ph_w   = ph_num[wcg_pkg::PH_Q_W-1:0];
    b_nxt.ph_d   = {a_r.nm1, 1'b0};
    b_nxt.rt_rem = wcg_pkg::RT_D_W'(rt_num >> wcg_pkg::RT_Q_W);
    b_nxt.rt_w   = rt_num[wcg_pkg::RT_Q_W-1:0];
    b_nxt.rt_d   = {den, 1'b0};
    b_nxt.wtype  = a_r.wtype;
    b_nxt.oor    = a_r.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign valid_o = b_valid_r;
  assign div_o   = b_r;

endmodule

// File: rtl/wcg_div.sv
// ----------------------------------------------------------------------------
// wcg_div - pipelined divider
// Phase lane gives round(j*2^32/(N-1)); ratio lane gives the Q15 ratio.
// ----------------------------------------------------------------------------
module wcg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  wcg_pkg::div_t     div_i,
  output logic              valid_o,
  output logic [31:0]       ph_o,
  output wcg_pkg::sb_t      sb_o
);

  localparam int LAST = wcg_pkg::DIV_STAGES - 1;

  logic [wcg_pkg::DIV_STAGES-1:0] valid_r;
  wcg_pkg::div_t                  st_r   [wcg_pkg::DIV_STAGES];
  wcg_pkg::div_t                  st_nxt [wcg_pkg::DIV_STAGES];

  // Each stage retires four quotient bits on the phase lane and two on the ratio lane
  for (genvar s = 0; s < wcg_pkg::DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb st_nxt[s] = wcg_pkg::div_stage(div_i);
    end else begin : g_rest
      always_comb st_nxt[s] = wcg_pkg::div_stage(st_r[s-1]);
    end
    always_ff @(posedge clk) begin
      st_r[s] <= st_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= {valid_r[wcg_pkg::DIV_STAGES-2:0], valid_i};
  end

  // Phase is taken mod 2^32
  assign valid_o      = valid_r[LAST];
  assign ph_o         = st_r[LAST].ph_w[31:0];
  assign sb_o.wtype   = st_r[LAST].wtype;
  assign sb_o.oor     = st_r[LAST].oor;
  assign sb_o.ratio_q = st_r[LAST].rt_w;

endmodule

// File: rtl/wcg_cos.sv
// ----------------------------------------------------------------------------
// wcg_cos - cosine of a phase in turns
// Quarter-turn fold, square, then a Horner stage per polynomial term below the top one.
// ----------------------------------------------------------------------------
module wcg_cos (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [31:0]       ph_i,
  output logic              valid_o,
  output wcg_pkg::q30_t     cos_o
);

  localparam int HS  = wcg_pkg::HORNER_STAGES;
  localparam int NEG = HS + 2;

  logic [wcg_pkg::COS_STAGES-1:0] valid_r;
  logic [NEG-1:0]                 neg_r;
  logic [wcg_pkg::Z_W-1:0]        u_r, u_nxt;
  logic [wcg_pkg::Z_W-1:0]        z_r;
  logic [2*wcg_pkg::Z_W-1:0]      sq;
  logic [31:0]                    f;
  logic                           neg_nxt;

  wcg_pkg::q30_t                  p_r  [HS];
  wcg_pkg::q30_t                  p_in [HS];
  logic [wcg_pkg::Z_W-1:0]        zh_r [HS];
  logic [wcg_pkg::Z_W-1:0]        z_in [HS];
  wcg_pkg::q30_t                  cos_r;

  // Fold onto a quarter turn
  always_comb begin
    f       = ph_i;
    neg_nxt = 1'b0;
    if (f > 32'h8000_0000) f = 32'h0 - f;
    if (f > 32'h4000_0000) begin
      f       = 32'h8000_0000 - f;
      neg_nxt = 1'b1;
    end
    u_nxt = f[wcg_pkg::Z_W-1:0];
  end

  assign sq = (2*wcg_pkg::Z_W)'(u_r) * (2*wcg_pkg::Z_W)'(u_r);

  // Horner chain, one multiply per stage
  for (genvar s = 0; s < HS; s++) begin : g_horner
    if (s == 0) begin : g_first
      assign p_in[s] = wcg_pkg::COS_POLY[HS];
      assign z_in[s] = z_r;
    end else begin : g_rest
      assign p_in[s] = p_r[s-1];
      assign z_in[s] = zh_r[s-1];
    end
    always_ff @(posedge clk) begin
      p_r[s]  <= wcg_pkg::COS_POLY[HS-1-s] - wcg_pkg::mulq(p_in[s], z_in[s]);
      zh_r[s] <= z_in[s];
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    z_r   <= sq[wcg_pkg::Z_W+29:30];
    neg_r <= {neg_r[NEG-2:0], neg_nxt};
    cos_r <= neg_r[NEG-1] ? -p_r[HS-1] : p_r[HS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= {valid_r[wcg_pkg::COS_STAGES-2:0], valid_i};
  end

  assign valid_o = valid_r[wcg_pkg::COS_STAGES-1];
  assign cos_o   = cos_r;

endmodule

// File: rtl/wcg_mix.sv
// ----------------------------------------------------------------------------
// wcg_mix - window combine and output register
// Weights the cosine terms, rounds to Q1.15 and selects by window type.
// ----------------------------------------------------------------------------
module wcg_mix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  input  wcg_pkg::q30_t                c1_i,
  input  wcg_pkg::q30_t                c2_i,
  input  wcg_pkg::sb_t                 sb_i,
  output logic                         valid_o,
  output logic [wcg_pkg::COEF_W-1:0]   coefficient_o,
  output logic                         oor_o
);

  logic                        valid1_r, valid2_r;
  wcg_pkg::sb_t                sb_r;
  wcg_pkg::q30_t               c1_r, ham_r, half_r, b08_r;
  wcg_pkg::q30_t               x, v, vc;
  logic [wcg_pkg::P_W-1:0]     rs;
  logic [wcg_pkg::COEF_W-1:0]  cos_coef, coef_nxt;
  logic [wcg_pkg::COEF_W-1:0]  coef_r;
  logic                        oor_r;

  // Stage 1: weight products
  always_ff @(posedge clk) begin
    sb_r   <= sb_i;
    c1_r   <= c1_i;
    ham_r  <= wcg_pkg::mulq(c1_i, wcg_pkg::K_H46);
    half_r <= wcg_pkg::mulq(c1_i, wcg_pkg::K_HALF);
    b08_r  <= wcg_pkg::mulq(c2_i, wcg_pkg::K_B08);
  end

  // Stage 2: sum, clamp, round, select
  always_comb begin
    x = wcg_pkg::Q30_ONE - c1_r;
    case (wcg_pkg::win_type_t'(sb_r.wtype))
      wcg_pkg::WIN_HANN:     v = x[wcg_pkg::P_W-1] ? '0 : (x >>> 1);
      wcg_pkg::WIN_HAMMING:  v = wcg_pkg::K_H54 - ham_r;
      wcg_pkg::WIN_BLACKMAN: v = wcg_pkg::K_B42 - half_r + b08_r;
      default:               v = '0;
    endcase
    if (v[wcg_pkg::P_W-1])        vc = '0;
    else if (v > wcg_pkg::Q30_ONE) vc = wcg_pkg::Q30_ONE;
    else                           vc = v;
    rs       = wcg_pkg::P_W'(vc) + wcg_pkg::P_W'(16384);
    cos_coef = rs[30:15];

    case (wcg_pkg::win_type_t'(sb_r.wtype)) inside
      wcg_pkg::WIN_TRI, wcg_pkg::WIN_PARZEN, wcg_pkg::WIN_WELCH: begin
        if (sb_r.ratio_q > wcg_pkg::RT_Q_W'(wcg_pkg::Q15_ONE)) coef_nxt = wcg_pkg::Q15_ONE;
        else coef_nxt = sb_r.ratio_q[wcg_pkg::COEF_W-1:0];
      end
      wcg_pkg::WIN_HANN, wcg_pkg::WIN_HAMMING, wcg_pkg::WIN_BLACKMAN: coef_nxt = cos_coef;
      default: coef_nxt = wcg_pkg::Q15_ONE;
    endcase
    if (sb_r.oor) coef_nxt = '0;
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    oor_r  <= sb_r.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= valid_i;
      valid2_r <= valid1_r;
    end
  end

  assign valid_o       = valid2_r;
  assign coefficient_o = coef_r;
  assign oor_o         = oor_r;

endmodule

// File: rtl/wcg_checker.sv
// ----------------------------------------------------------------------------
// wcg_checker - port-level checks
// Watches the top level's ports for range, latency and unknown-value slips.
// ----------------------------------------------------------------------------
module wcg_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [wcg_pkg::IDX_W-1:0]         in_sample_index,
  input  logic                              out_valid,
  input  logic [wcg_pkg::COEF_W-1:0]        out_coefficient,
  input  logic                              out_index_out_of_range,
  input  logic                              cfg_we,
  input  logic [wcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Coefficient never exceeds 1.0
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coefficient <= wcg_pkg::Q15_ONE)
    else $error("coefficient above 1.0");

  // Out-of-range index gives zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_out_of_range |-> out_coefficient == '0)
    else $error("out-of-range index with nonzero coefficient");

  // Every result traces back to a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, wcg_pkg::LATENCY))
    else $error("result without matching input transfer");

  // Sample index is defined on every input transfer
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_sample_index))
    else $error("unknown sample index on input transfer");

  // Register index and data are defined on every write
  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !$isunknown({cfg_index, cfg_data}))
    else $error("unknown register write");

endmodule

bind window_coefficient_generator wcg_checker u_wcg_checker (.*);

// File: tb/tb_window_coefficient_generator.sv
// ----------------------------------------------------------------------------
// tb_window_coefficient_generator - window coefficient generator regression
// Sends sample indexes under several window types and lengths. A bit-exact
// predictor in the scoreboard works out each coefficient and the
// out-of-range flag, and every result is checked in order against it.
// ----------------------------------------------------------------------------

// Scoreboard: predicts coefficients and checks results in arrival order
class coef_scoreboard;
  logic [wcg_pkg::TYPE_W-1:0]  wtype;
  logic [wcg_pkg::LEN_W-1:0]   wlen;
  logic [wcg_pkg::COEF_W-1:0]  coef_q[$];
  logic                        oor_q[$];
  int                          mismatches;
  int                          checked;

  function new();
    wtype      = wcg_pkg::WIN_RECT;
    wlen       = wcg_pkg::LEN_RESET;
    mismatches = 0;
    checked    = 0;
  endfunction

  // Signed Q30 times unsigned Q30, truncated toward zero
  function longint q30_mul(longint a, longint b);
    if (a < 0) return -((-a * b) >>> 30);
    return (a * b) >>> 30;
  endfunction

  // Cosine of a phase given as a fraction of a turn
  function longint cos_of_turn(logic [31:0] ph);
    longint poly[7];
    bit     neg;
    longint u;
    longint z;
    longint p;
    poly = '{64'd1073741824, 64'd1324675879, 64'd272375560, 64'd22401993,
             64'd987048, 64'd27061, 64'd506};
    neg = 0;
    if (ph > 32'h8000_0000) ph = 32'd0 - ph;
    if (ph > 32'h4000_0000) begin
      ph  = 32'h8000_0000 - ph;
      neg = 1;
    end
    u = ph;
    z = (u * u) >> 30;
    p = poly[6];
    for (int k = 5; k >= 0; k--) p = poly[k] - q30_mul(p, z);
    return neg ? -p : p;
  endfunction

  function longint q30_to_q15(longint v);
    if (v < 0) v = 0;
    if (v > 64'd1073741824) v = 64'd1073741824;
    return (v + 16384) >> 15;
  endfunction

  function longint ratio_q15(longint num, longint den);
    return (num * 65536 + den) / (2 * den);
  endfunction

  function void write_reg(logic [wcg_pkg::CFG_IDX_W-1:0] idx,
                          logic [wcg_pkg::CFG_DATA_W-1:0] val);
    if (idx == wcg_pkg::CFG_WINDOW_TYPE) wtype = val[wcg_pkg::TYPE_W-1:0];
    else if (idx == wcg_pkg::CFG_WINDOW_LENGTH) wlen = val[wcg_pkg::LEN_W-1:0];
  endfunction

  // Note an accepted sample index and queue its expected result
  function void note_index(logic [wcg_pkg::IDX_W-1:0] idx);
    longint      j;
    longint      n;
    longint      nm1;
    longint      d;
    longint      m;
    longint      c1;
    longint      c2;
    longint      coef;
    logic [31:0] ph;
    j = idx;
    n = wlen;
    if (n < 2) n = 2;
    if (n > wcg_pkg::MAX_LENGTH) n = wcg_pkg::MAX_LENGTH;
    nm1 = n - 1;
    if (j > nm1) begin
      coef_q.push_back('0);
      oor_q.push_back(1'b1);
      return;
    end
    ph   = 32'(((j << 33) + nm1) / (2 * nm1));
    d    = (2 * j >= nm1) ? 2 * j - nm1 : nm1 - 2 * j;
    m    = (j < nm1 - j) ? j : nm1 - j;
    coef = 32768;
    case (wtype)
      wcg_pkg::WIN_TRI:     coef = ratio_q15(2 * m, nm1);
      wcg_pkg::WIN_HANN:    coef = q30_to_q15((64'd1073741824 - cos_of_turn(ph)) / 2);
      wcg_pkg::WIN_HAMMING: coef = q30_to_q15(64'd579820585 -
                                              q30_mul(cos_of_turn(ph), 64'd493921239));
      wcg_pkg::WIN_BLACKMAN: begin
        c1   = cos_of_turn(ph);
        c2   = cos_of_turn(ph * 2);
        coef = q30_to_q15(64'd450971566 - q30_mul(c1, 64'd536870912)
                          + q30_mul(c2, 64'd85899346));
      end
      wcg_pkg::WIN_PARZEN:  coef = ratio_q15(n + 1 - d, n + 1);
      wcg_pkg::WIN_WELCH:   coef = ratio_q15((n + 1) * (n + 1) - d * d,
                                             (n + 1) * (n + 1));
      default:              coef = 32768;
    endcase
    if (coef > 32768) coef = 32768;
    coef_q.push_back(coef[wcg_pkg::COEF_W-1:0]);
    oor_q.push_back(1'b0);
  endfunction

  // Compare a result with the oldest expectation
  function void check_result(logic [wcg_pkg::COEF_W-1:0] coef, logic oor);
    logic [wcg_pkg::COEF_W-1:0] exp_coef;
    logic                       exp_oor;
    if (coef_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: coefficient %0d flag %0b", coef, oor);
      return;
    end
    exp_coef = coef_q.pop_front();
    exp_oor  = oor_q.pop_front();
    checked++;
    if (coef !== exp_coef || oor !== exp_oor) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: coefficient exp %0d got %0d, flag exp %0b got %0b",
                 exp_coef, coef, exp_oor, oor);
    end
  endfunction

  function int pending();
    return coef_q.size();
  endfunction
endclass

module tb_window_coefficient_generator;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 550;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [wcg_pkg::IDX_W-1:0]      in_sample_index;
  logic                           out_valid;
  logic [wcg_pkg::COEF_W-1:0]     out_coefficient;
  logic                           out_index_out_of_range;
  logic                           cfg_we;
  logic [wcg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wcg_pkg::CFG_DATA_W-1:0] cfg_data;

  coef_scoreboard sb;
  int             cycles;
  bit             allow_idle;
  int             type_hits[8];

  window_coefficient_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_index(in_sample_index), .out_valid(out_valid),
    .out_coefficient(out_coefficient),
    .out_index_out_of_range(out_index_out_of_range),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Sample transfers at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_index(in_sample_index);
      if (out_valid) sb.check_result(out_coefficient, out_index_out_of_range);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("window_coefficient_generator regression: fail");
      $finish;
    end
  end

  // Send one sample index, with an optional idle burst first; start stays
  // high afterwards so that items can follow back to back
  task automatic send_index(logic [wcg_pkg::IDX_W-1:0] idx);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start           <= 1'b1;
    in_sample_index <= idx;
    type_hits[sb.wtype]++;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the pipeline drain
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (wcg_pkg::LATENCY + 4) @(negedge clk);
  endtask

  // One register write; the enable is dropped by the caller
  task automatic write_reg(logic [wcg_pkg::CFG_IDX_W-1:0] idx,
                           logic [wcg_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_window(logic [wcg_pkg::TYPE_W-1:0] t,
                            logic [wcg_pkg::CFG_DATA_W-1:0] n);
    drain();
    write_reg(wcg_pkg::CFG_WINDOW_TYPE, wcg_pkg::CFG_DATA_W'(t));
    write_reg(wcg_pkg::CFG_WINDOW_LENGTH, n);
    cfg_we <= 1'b0;
  endtask

  // Random index within the window, with some past its end
  function automatic logic [wcg_pkg::IDX_W-1:0] pick_index();
    int n;
    n = sb.wlen;
    if (n < 2) n = 2;
    if (n > wcg_pkg::MAX_LENGTH) n = wcg_pkg::MAX_LENGTH;
    case ($urandom_range(0, 9))
      0:       return wcg_pkg::IDX_W'($urandom);
      1:       return wcg_pkg::IDX_W'(n - 1);
      2:       return '0;
      default: return wcg_pkg::IDX_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  initial begin
    logic [wcg_pkg::CFG_DATA_W-1:0] lens[8];
    lens = '{13'd2, 13'd3, 13'd0, 13'd4096, 13'd8191, 13'd17, 13'd256, 13'd1000};
    sb              = new();
    cycles          = 0;
    allow_idle      = 1;
    start           = 1'b0;
    in_sample_index = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    rst_n           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, ends of the index, every type at extremes
    send_index(0);
    send_index(255);
    send_index(256);
    send_index(12'hFFF);
    for (int t = 0; t < 8; t++) begin
      set_window(wcg_pkg::TYPE_W'(t), (t % 2) ? 13'd4096 : 13'd5);
      send_index(0);
      send_index(wcg_pkg::IDX_W'(sb.wlen / 2));
      send_index(12'hFFF);
    end
    // Length below minimum and above maximum are clamped
    set_window(wcg_pkg::WIN_HANN, 13'd0);
    send_index(1);
    send_index(2);
    set_window(wcg_pkg::WIN_WELCH, 13'd8191);
    send_index(12'hFFF);

    // Random phases over several settings, idling off in the last part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        if (i >= RANDOM_ITEMS - 100) allow_idle = 0;
        set_window(wcg_pkg::TYPE_W'($urandom_range(0, 7)),
                   ($urandom_range(0, 2) == 0) ? lens[$urandom_range(0, 7)]
                                               : wcg_pkg::CFG_DATA_W'($urandom));
      end
      if (i == 275) drain();
      send_index(pick_index());
    end

    drain();
    $display("checked %0d results, hits by type %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.checked, type_hits[0], type_hits[1], type_hits[2], type_hits[3],
             type_hits[4], type_hits[5], type_hits[6], type_hits[7]);
    $display("lengths included 0, 2, 3, 4096 and 8191; mismatches %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("window_coefficient_generator regression: pass");
    else
      $display("window_coefficient_generator regression: fail");
    $finish;
  end
endmodule
